@@ hdl/vdr_pkg.sv @@
// ----------------------------------------------------------------------------
// vdr_pkg: shared types and constants for the voxel disc rasterizer
// Micro-operation encoding and the micro-program of the shared multiply-
// accumulate unit, plus register indexes of the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

package vdr_pkg;

  localparam int unsigned SRC_W = 18;
  localparam int unsigned PROD_W = 2 * SRC_W;
  localparam int unsigned ACC_W = 56;
  localparam int unsigned CNT_W = 24;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [2:0] REG_ROT_COS = 3'd0;
  localparam logic [2:0] REG_ROT_SIN = 3'd1;
  localparam logic [2:0] REG_ANGLE_STEPS = 3'd2;
  localparam logic [2:0] REG_RADIUS = 3'd3;
  localparam logic [2:0] REG_STEP_SIZE = 3'd4;
  localparam logic [2:0] REG_SCALE_X = 3'd5;
  localparam logic [2:0] REG_SCALE_Y = 3'd6;
  localparam logic [2:0] REG_SCALE_Z = 3'd7;

  typedef enum logic [5:0] {
    SRC_COS, SRC_SIN, SRC_B, SRC_C, SRC_D,
    SRC_AX0, SRC_AX1, SRC_AX2,
    SRC_M0, SRC_M1, SRC_M2, SRC_M3, SRC_M4, SRC_M5, SRC_M6, SRC_M7, SRC_M8,
    SRC_DIR0, SRC_DIR1, SRC_DIR2,
    SRC_SC0, SRC_SC1, SRC_SC2,
    SRC_ST, SRC_R,
    SRC_DSLO0, SRC_DSLO1, SRC_DSLO2,
    SRC_DSHI0, SRC_DSHI1, SRC_DSHI2,
    SRC_CTR0, SRC_CTR1, SRC_CTR2,
    SRC_K26, SRC_ONE, SRC_DY, SRC_DZ, SRC_DYZLO, SRC_DYZHI,
    SRC_P0, SRC_P1, SRC_P2
  } src_e;

  typedef enum logic [4:0] {
    DST_NONE, DST_B, DST_C, DST_D,
    DST_M0, DST_M1, DST_M2, DST_M3, DST_M4, DST_M5, DST_M6, DST_M7, DST_M8,
    DST_DS0, DST_DS1, DST_DS2,
    DST_INC0, DST_INC1, DST_INC2,
    DST_POS0, DST_POS1, DST_POS2,
    DST_ND0, DST_ND1, DST_ND2,
    DST_VOX
  } dst_e;

  typedef enum logic [1:0] {
    RND_RAW, RND_R14, RND_R13S, RND_R14S
  } rnd_e;

  typedef struct packed {
    src_e a;
    src_e b;
    logic neg;   // subtract the product
    logic sh16;  // product weighted by 2^16
    logic clr;   // start a new sum
    logic wr;    // store the sum after this operation
    dst_e dst;
    rnd_e rnd;
  } uop_t;

  localparam logic [5:0] UOP_SETUP_END = 6'd26;
  localparam logic [5:0] UOP_ANGLE = 6'd27;
  localparam logic [5:0] UOP_ANGLE_END = 6'd44;
  localparam logic [5:0] UOP_IDX = 6'd45;
  localparam logic [5:0] UOP_IDX_END = 6'd48;
  localparam logic [5:0] UOP_ROT = 6'd49;
  localparam logic [5:0] UOP_ROT_END = 6'd57;

  function automatic uop_t mk(src_e a, src_e b, logic neg, logic sh16, logic clr,
                              logic wr, dst_e dst, rnd_e rnd);
    uop_t u;
    u.a = a;
    u.b = b;
    u.neg = neg;
    u.sh16 = sh16;
    u.clr = clr;
    u.wr = wr;
    u.dst = dst;
    u.rnd = rnd;
    return u;
  endfunction

  function automatic uop_t uop_rom(logic [5:0] idx);
    uop_t u;
    unique case (idx)
      // b, c, d from the axis and the sine
      6'd0: u = mk(SRC_AX0, SRC_SIN, 1'b0, 1'b0, 1'b1, 1'b1, DST_B, RND_R14);
      6'd1: u = mk(SRC_AX1, SRC_SIN, 1'b0, 1'b0, 1'b1, 1'b1, DST_C, RND_R14);
      6'd2: u = mk(SRC_AX2, SRC_SIN, 1'b0, 1'b0, 1'b1, 1'b1, DST_D, RND_R14);
      // Rotation matrix.
      6'd3: u = mk(SRC_COS, SRC_COS, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, RND_RAW);
      6'd4: u = mk(SRC_B, SRC_B, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE, RND_RAW);
      6'd5: u = mk(SRC_C, SRC_C, 1'b1, 1'b0, 1'b0, 1'b0, DST_NONE, RND_RAW);
      6'd6: u = mk(SRC_D, SRC_D, 1'b1, 1'b0, 1'b0, 1'b1, DST_M0, RND_R14S);
      6'd7: u = mk(SRC_B, SRC_C, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, RND_RAW);
      6'd8: u = mk(SRC_D, SRC_COS, 1'b1, 1'b0, 1'b0, 1'b1, DST_M1, RND_R13S);
      6'd9: u = mk(SRC_B, SRC_D, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, RND_RAW);
      6'd10: u = mk(SRC_COS, SRC_C, 1'b0, 1'b0, 1'b0, 1'b1, DST_M2, RND_R13S);
      6'd11: u = mk(SRC_B, SRC_C, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, RND_RAW);
      6'd12: u = mk(SRC_COS, SRC_D, 1'b0, 1'b0, 1'b0, 1'b1, DST_M3, RND_R13S);
      6'd13: u = mk(SRC_COS, SRC_COS, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, RND_RAW);
      6'd14: u = mk(SRC_C, SRC_C, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE, RND_RAW);
      6'd15: u = mk(SRC_B, SRC_B, 1'b1, 1'b0, 1'b0, 1'b0, DST_NONE, RND_RAW);
      6'd16: u = mk(SRC_D, SRC_D, 1'b1, 1'b0, 1'b0, 1'b1, DST_M4, RND_R14S);
      6'd17: u = mk(SRC_C, SRC_D, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, RND_RAW);
      6'd18: u = mk(SRC_COS, SRC_B, 1'b1, 1'b0, 1'b0, 1'b1, DST_M5, RND_R13S);
      6'd19: u = mk(SRC_B, SRC_D, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, RND_RAW);
      6'd20: u = mk(SRC_COS, SRC_C, 1'b1, 1'b0, 1'b0, 1'b1, DST_M6, RND_R13S);
      6'd21: u = mk(SRC_C, SRC_D, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, RND_RAW);
      6'd22: u = mk(SRC_COS, SRC_B, 1'b0, 1'b0, 1'b0, 1'b1, DST_M7, RND_R13S);
      6'd23: u = mk(SRC_COS, SRC_COS, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, RND_RAW);
      6'd24: u = mk(SRC_D, SRC_D, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE, RND_RAW);
      6'd25: u = mk(SRC_C, SRC_C, 1'b1, 1'b0, 1'b0, 1'b0, DST_NONE, RND_RAW);
      6'd26: u = mk(SRC_B, SRC_B, 1'b1, 1'b0, 1'b0, 1'b1, DST_M8, RND_R14S);
      // Per angle: scaled direction, step increment and start position.
      6'd27: u = mk(SRC_DIR0, SRC_SC0, 1'b0, 1'b0, 1'b1, 1'b1, DST_DS0, RND_RAW);
      6'd28: u = mk(SRC_DIR1, SRC_SC1, 1'b0, 1'b0, 1'b1, 1'b1, DST_DS1, RND_RAW);
      6'd29: u = mk(SRC_DIR2, SRC_SC2, 1'b0, 1'b0, 1'b1, 1'b1, DST_DS2, RND_RAW);
      6'd30: u = mk(SRC_ST, SRC_DSLO0, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, RND_RAW);
      6'd31: u = mk(SRC_ST, SRC_DSHI0, 1'b0, 1'b1, 1'b0, 1'b1, DST_INC0, RND_RAW);
      6'd32: u = mk(SRC_ST, SRC_DSLO1, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, RND_RAW);
      6'd33: u = mk(SRC_ST, SRC_DSHI1, 1'b0, 1'b1, 1'b0, 1'b1, DST_INC1, RND_RAW);
      6'd34: u = mk(SRC_ST, SRC_DSLO2, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, RND_RAW);
      6'd35: u = mk(SRC_ST, SRC_DSHI2, 1'b0, 1'b1, 1'b0, 1'b1, DST_INC2, RND_RAW);
      6'd36: u = mk(SRC_CTR0, SRC_K26, 1'b0, 1'b1, 1'b1, 1'b0, DST_NONE, RND_RAW);
      6'd37: u = mk(SRC_R, SRC_DSLO0, 1'b1, 1'b0, 1'b0, 1'b0, DST_NONE, RND_RAW);
      6'd38: u = mk(SRC_R, SRC_DSHI0, 1'b1, 1'b1, 1'b0, 1'b1, DST_POS0, RND_RAW);
      6'd39: u = mk(SRC_CTR1, SRC_K26, 1'b0, 1'b1, 1'b1, 1'b0, DST_NONE, RND_RAW);
      6'd40: u = mk(SRC_R, SRC_DSLO1, 1'b1, 1'b0, 1'b0, 1'b0, DST_NONE, RND_RAW);
      6'd41: u = mk(SRC_R, SRC_DSHI1, 1'b1, 1'b1, 1'b0, 1'b1, DST_POS1, RND_RAW);
      6'd42: u = mk(SRC_CTR2, SRC_K26, 1'b0, 1'b1, 1'b1, 1'b0, DST_NONE, RND_RAW);
      6'd43: u = mk(SRC_R, SRC_DSLO2, 1'b1, 1'b0, 1'b0, 1'b0, DST_NONE, RND_RAW);
      6'd44: u = mk(SRC_R, SRC_DSHI2, 1'b1, 1'b1, 1'b0, 1'b1, DST_POS2, RND_RAW);
      // Flat voxel index of the current point.
      6'd45: u = mk(SRC_P0, SRC_DYZLO, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, RND_RAW);
      6'd46: u = mk(SRC_P0, SRC_DYZHI, 1'b0, 1'b1, 1'b0, 1'b0, DST_NONE, RND_RAW);
      6'd47: u = mk(SRC_P1, SRC_DZ, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE, RND_RAW);
      6'd48: u = mk(SRC_P2, SRC_ONE, 1'b0, 1'b0, 1'b0, 1'b1, DST_VOX, RND_RAW);
      // Direction rotation.
      6'd49: u = mk(SRC_M0, SRC_DIR0, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, RND_RAW);
      6'd50: u = mk(SRC_M1, SRC_DIR1, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE, RND_RAW);
      6'd51: u = mk(SRC_M2, SRC_DIR2, 1'b0, 1'b0, 1'b0, 1'b1, DST_ND0, RND_R14S);
      6'd52: u = mk(SRC_M3, SRC_DIR0, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, RND_RAW);
      6'd53: u = mk(SRC_M4, SRC_DIR1, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE, RND_RAW);
      6'd54: u = mk(SRC_M5, SRC_DIR2, 1'b0, 1'b0, 1'b0, 1'b1, DST_ND1, RND_R14S);
      6'd55: u = mk(SRC_M6, SRC_DIR0, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, RND_RAW);
      6'd56: u = mk(SRC_M7, SRC_DIR1, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE, RND_RAW);
      6'd57: u = mk(SRC_M8, SRC_DIR2, 1'b0, 1'b0, 1'b0, 1'b1, DST_ND2, RND_R14S);
      default: u = mk(SRC_ONE, SRC_ONE, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, RND_RAW);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

@@ hdl/vdr_if.sv @@
// ----------------------------------------------------------------------------
// vdr_if: request and response channels of the voxel disc rasterizer
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface vdr_req_if;
  logic valid;
  logic ready;
  logic req_type;
  logic signed [17:0] center_x;
  logic signed [17:0] center_y;
  logic signed [17:0] center_z;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic signed [15:0] start_z;
  logic [17:0] voxel_index;

  modport source (
    output valid, req_type, center_x, center_y, center_z, axis_x, axis_y, axis_z,
           start_x, start_y, start_z, voxel_index,
    input ready
  );
  modport sink (
    input valid, req_type, center_x, center_y, center_z, axis_x, axis_y, axis_z,
          start_x, start_y, start_z, voxel_index,
    output ready
  );
endinterface

interface vdr_rsp_if;
  logic valid;
  logic ready;
  logic voxel_value;
  logic [23:0] voxels_written;

  modport source (output valid, voxel_value, voxels_written, input ready);
  modport sink (input valid, voxel_value, voxels_written, output ready);
endinterface

`default_nettype wire

@@ hdl/voxel_disc_rasterizer_top.sv @@
// ----------------------------------------------------------------------------
// voxel_disc_rasterizer_top: binary voxel volume with rotated-line disc drawing
// Draw requests sweep rotated lines through the volume; read requests return
// one voxel. All multiplies use one shared 18x18 multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Content
// req_i     in         valid/ready        draw or read request
// rsp_o     out        valid/ready        voxel value and write count
// cfg       in         cfg_we_i only      rotation, steps, radius, step, scales
//
// After reset the volume is cleared one voxel a cycle, and no request is
// taken until the clearing pass is over.
// A draw first sets up the rotation matrix, then per angle sets up the line
// and steps through its points. Every multiply-add of the shared unit has a
// multiply and an accumulate phase, and a stored result a write phase.
// A finished response waits in its own register; a new request is taken
// while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_disc_rasterizer_top #(
  parameter int unsigned DIM_X = 64,
  parameter int unsigned DIM_Y = 64,
  parameter int unsigned DIM_Z = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  vdr_req_if.sink          req_i,
  vdr_rsp_if.source        rsp_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  import vdr_pkg::*;

  localparam int unsigned VOL = DIM_X * DIM_Y * DIM_Z;
  localparam int unsigned AW = (VOL > 1) ? $clog2(VOL) : 1;
  localparam int unsigned DYZ = DIM_Y * DIM_Z;
  localparam logic signed [SRC_W-1:0] K_DY = SRC_W'(DIM_Y);
  localparam logic signed [SRC_W-1:0] K_DZ = SRC_W'(DIM_Z);
  localparam logic signed [SRC_W-1:0] K_DYZLO = SRC_W'(DYZ % 65536);
  localparam logic signed [SRC_W-1:0] K_DYZHI = SRC_W'(DYZ / 65536);
  localparam logic signed [SRC_W-1:0] K_26 = SRC_W'(1024);
  localparam logic signed [SRC_W-1:0] K_ONE = SRC_W'(1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD, S_MAC, S_PT, S_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_MUL, PH_ACC, PH_WR
  } phase_e;

  // Control state.
  state_e state_q;
  phase_e ph_q;
  logic [5:0] uop_q;
  logic [1:0] k_q;
  logic [10:0] ang_q;
  logic signed [18:0] t_q;
  logic [CNT_W-1:0] cnt_q;
  logic [AW-1:0] clr_addr_q;
  logic typ_q;
  logic inr_q;
  logic out_vld_q;
  logic out_val_q;
  logic [CNT_W-1:0] out_cnt_q;

  // Configuration.
  logic signed [15:0] cos_q, sin_q;
  logic [10:0] steps_q;
  logic [15:0] radius_q, step_q;
  logic [15:0] sc_q [3];

  // Datapath.
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [SRC_W-1:0] b_q, c_q, d_q;
  logic signed [15:0] m_q [9];
  logic signed [15:0] dir_q [3];
  logic signed [15:0] nd0_q, nd1_q;
  logic signed [33:0] ds_q [3];
  logic signed [ACC_W-1:0] inc_q [3];
  logic signed [ACC_W-1:0] pos_q [3];
  logic signed [SRC_W-1:0] p_q [3];
  logic signed [SRC_W-1:0] ctr_q [3];
  logic signed [15:0] ax_q [3];
  logic [AW-1:0] idx_q;

  logic vol_mem [VOL];
  logic rd_q;

  uop_t uop;
  logic accept;
  logic mac_done;
  logic [15:0] st_eff;
  logic [10:0] steps_eff;
  logic signed [SRC_W-1:0] opa, opb;
  logic signed [ACC_W-1:0] prod_ext, prod_sh, acc_nx;
  logic signed [ACC_W-1:0] roff, rsum, rval;
  logic signed [15:0] rsat;
  logic signed [ACC_W-1:0] pv, poff, psum, pr;
  logic signed [18:0] t_nx, r_ext;
  logic [11:0] ang_nx;
  logic vox_in;
  logic vox_we;
  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0] req_idx32;

  function automatic logic signed [SRC_W-1:0] src_val(src_e s);
    logic signed [SRC_W-1:0] v;
    case (s)
      SRC_COS: v = SRC_W'(cos_q);
      SRC_SIN: v = SRC_W'(sin_q);
      SRC_B: v = b_q;
      SRC_C: v = c_q;
      SRC_D: v = d_q;
      SRC_AX0: v = SRC_W'(ax_q[0]);
      SRC_AX1: v = SRC_W'(ax_q[1]);
      SRC_AX2: v = SRC_W'(ax_q[2]);
      SRC_M0: v = SRC_W'(m_q[0]);
      SRC_M1: v = SRC_W'(m_q[1]);
      SRC_M2: v = SRC_W'(m_q[2]);
      SRC_M3: v = SRC_W'(m_q[3]);
      SRC_M4: v = SRC_W'(m_q[4]);
      SRC_M5: v = SRC_W'(m_q[5]);
      SRC_M6: v = SRC_W'(m_q[6]);
      SRC_M7: v = SRC_W'(m_q[7]);
      SRC_M8: v = SRC_W'(m_q[8]);
      SRC_DIR0: v = SRC_W'(dir_q[0]);
      SRC_DIR1: v = SRC_W'(dir_q[1]);
      SRC_DIR2: v = SRC_W'(dir_q[2]);
      SRC_SC0: v = {2'b00, sc_q[0]};
      SRC_SC1: v = {2'b00, sc_q[1]};
      SRC_SC2: v = {2'b00, sc_q[2]};
      SRC_ST: v = {2'b00, st_eff};
      SRC_R: v = {2'b00, radius_q};
      SRC_DSLO0: v = {2'b00, ds_q[0][15:0]};
      SRC_DSLO1: v = {2'b00, ds_q[1][15:0]};
      SRC_DSLO2: v = {2'b00, ds_q[2][15:0]};
      SRC_DSHI0: v = ds_q[0][33:16];
      SRC_DSHI1: v = ds_q[1][33:16];
      SRC_DSHI2: v = ds_q[2][33:16];
      SRC_CTR0: v = ctr_q[0];
      SRC_CTR1: v = ctr_q[1];
      SRC_CTR2: v = ctr_q[2];
      SRC_K26: v = K_26;
      SRC_ONE: v = K_ONE;
      SRC_DY: v = K_DY;
      SRC_DZ: v = K_DZ;
      SRC_DYZLO: v = K_DYZLO;
      SRC_DYZHI: v = K_DYZHI;
      SRC_P0: v = p_q[0];
      SRC_P1: v = p_q[1];
      SRC_P2: v = p_q[2];
      default: v = '0;
    endcase
    return v;
  endfunction

  assign uop = uop_rom(uop_q);
  assign accept = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = out_vld_q;
  assign rsp_o.voxel_value = out_val_q;
  assign rsp_o.voxels_written = out_cnt_q;

  assign st_eff = (step_q == 16'd0) ? 16'd1 : step_q;
  assign steps_eff = (steps_q == 11'd0) ? 11'd1 : steps_q;
  assign r_ext = {3'b000, radius_q};
  assign t_nx = t_q + 19'($signed({3'b000, st_eff}));
  assign ang_nx = {1'b0, ang_q} + 12'd1;
  assign req_idx32 = {14'd0, req_i.voxel_index};

  // Shared multiply-accumulate unit.
  always_comb begin
    opa = src_val(uop.a);
    opb = src_val(uop.b);
    prod_ext = ACC_W'(prod_q);
    prod_sh = uop.sh16 ? (prod_ext <<< 16) : prod_ext;
    acc_nx = (uop.clr ? '0 : acc_q) + (uop.neg ? -prod_sh : prod_sh);
  end

  // Half-away-from-zero rounding of the sum, with a single add, and a copy saturated to 16 bits.
  always_comb begin
    if (uop.rnd == RND_R13S) begin
      roff = acc_q[ACC_W-1] ? ACC_W'(4095) : ACC_W'(4096);
    end else begin
      roff = acc_q[ACC_W-1] ? ACC_W'(8191) : ACC_W'(8192);
    end
    rsum = acc_q + roff;
    rval = (uop.rnd == RND_R13S) ? (rsum >>> 13) : (rsum >>> 14);
    if (rval > ACC_W'(32767)) begin
      rsat = 16'sd32767;
    end else if (rval < -ACC_W'(32768)) begin
      rsat = -16'sd32768;
    end else begin
      rsat = rval[15:0];
    end
  end

  // Point rounding to whole voxels.
  always_comb begin
    pv = pos_q[k_q];
    poff = pv[ACC_W-1] ? ((ACC_W'(1) <<< 33) - ACC_W'(1)) : (ACC_W'(1) <<< 33);
    psum = pv + poff;
    pr = psum >>> 34;
  end

  assign mac_done = (state_q == S_MAC)
                    && ((ph_q == PH_ACC && !uop.wr) || ph_q == PH_WR);
  assign vox_in = !acc_q[ACC_W-1] && (acc_q[ACC_W-2:0] < (ACC_W-1)'(VOL));
  assign vox_we = (state_q == S_MAC) && (ph_q == PH_WR) && (uop.dst == DST_VOX)
                  && vox_in;
  assign mem_we = (state_q == S_CLEAR) || vox_we;
  assign mem_waddr = (state_q == S_CLEAR) ? clr_addr_q : acc_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      vol_mem[mem_waddr] <= (state_q != S_CLEAR);
    end
    rd_q <= vol_mem[idx_q];
  end

  // Control and sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ph_q <= PH_MUL;
      uop_q <= '0;
      k_q <= '0;
      ang_q <= '0;
      t_q <= '0;
      cnt_q <= '0;
      clr_addr_q <= '0;
      typ_q <= 1'b0;
      inr_q <= 1'b0;
      out_vld_q <= 1'b0;
      out_val_q <= 1'b0;
      out_cnt_q <= '0;
      cos_q <= 16'sd16302;
      sin_q <= 16'sd1636;
      steps_q <= 11'd32;
      radius_q <= 16'd1280;
      step_q <= 16'd128;
      sc_q[0] <= 16'd4096;
      sc_q[1] <= 16'd4096;
      sc_q[2] <= 16'd4096;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ROT_COS: cos_q <= cfg_data_i;
          REG_ROT_SIN: sin_q <= cfg_data_i;
          REG_ANGLE_STEPS: steps_q <= cfg_data_i[10:0];
          REG_RADIUS: radius_q <= cfg_data_i;
          REG_STEP_SIZE: step_q <= cfg_data_i;
          REG_SCALE_X: sc_q[0] <= cfg_data_i;
          REG_SCALE_Y: sc_q[1] <= cfg_data_i;
          REG_SCALE_Z: sc_q[2] <= cfg_data_i;
          default: ;
        endcase
      end

      // The finishing state reloads the response register itself.
      if (rsp_o.valid && rsp_o.ready && state_q != S_DONE) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + AW'(1);
          if (clr_addr_q == AW'(VOL - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            typ_q <= req_i.req_type;
            inr_q <= (req_idx32 < 32'(VOL));
            cnt_q <= '0;
            ang_q <= '0;
            uop_q <= '0;
            ph_q <= PH_MUL;
            t_q <= -r_ext;
            state_q <= req_i.req_type ? S_RD : S_MAC;
          end
        end
        S_RD: begin
          state_q <= S_DONE;
        end
        S_MAC: begin
          if (ph_q == PH_MUL) begin
            ph_q <= PH_ACC;
          end else if (ph_q == PH_ACC && uop.wr) begin
            ph_q <= PH_WR;
          end else begin
            ph_q <= PH_MUL;
          end
          if (vox_we && cnt_q != CNT_MAX) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
          if (mac_done) begin
            if (uop_q == UOP_SETUP_END) begin
              uop_q <= UOP_ANGLE;
              t_q <= -r_ext;
            end else if (uop_q == UOP_ANGLE_END) begin
              state_q <= S_PT;
              k_q <= '0;
            end else if (uop_q == UOP_IDX_END) begin
              t_q <= t_nx;
              if (t_nx < r_ext) begin
                state_q <= S_PT;
                k_q <= '0;
              end else begin
                uop_q <= UOP_ROT;
              end
            end else if (uop_q == UOP_ROT_END) begin
              ang_q <= ang_nx[10:0];
              if (ang_nx < {1'b0, steps_eff}) begin
                uop_q <= UOP_ANGLE;
                t_q <= -r_ext;
              end else begin
                state_q <= S_DONE;
              end
            end else begin
              uop_q <= uop_q + 6'd1;
            end
          end
        end
        S_PT: begin
          k_q <= k_q + 2'd1;
          if (k_q == 2'd2) begin
            state_q <= S_MAC;
            uop_q <= UOP_IDX;
            ph_q <= PH_MUL;
          end
        end
        S_DONE: begin
          if (!out_vld_q || rsp_o.ready) begin
            out_vld_q <= 1'b1;
            out_val_q <= typ_q && inr_q && rd_q;
            out_cnt_q <= typ_q ? '0 : cnt_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctr_q[0] <= req_i.center_x;
      ctr_q[1] <= req_i.center_y;
      ctr_q[2] <= req_i.center_z;
      ax_q[0] <= req_i.axis_x;
      ax_q[1] <= req_i.axis_y;
      ax_q[2] <= req_i.axis_z;
      dir_q[0] <= req_i.start_x;
      dir_q[1] <= req_i.start_y;
      dir_q[2] <= req_i.start_z;
      idx_q <= req_idx32[AW-1:0];
    end
    if (state_q == S_MAC && ph_q == PH_MUL) begin
      prod_q <= opa * opb;
    end
    if (state_q == S_MAC && ph_q == PH_ACC) begin
      acc_q <= acc_nx;
    end
    if (state_q == S_PT) begin
      p_q[k_q] <= pr[SRC_W-1:0];
      pos_q[k_q] <= pv + inc_q[k_q];
    end
    if (state_q == S_MAC && ph_q == PH_WR) begin
      case (uop.dst)
        DST_B: b_q <= rval[SRC_W-1:0];
        DST_C: c_q <= rval[SRC_W-1:0];
        DST_D: d_q <= rval[SRC_W-1:0];
        DST_M0, DST_M1, DST_M2, DST_M3, DST_M4, DST_M5, DST_M6, DST_M7, DST_M8:
          m_q[4'(uop.dst - DST_M0)] <= rsat;
        DST_DS0, DST_DS1, DST_DS2: ds_q[2'(uop.dst - DST_DS0)] <= acc_q[33:0];
        DST_INC0, DST_INC1, DST_INC2: inc_q[2'(uop.dst - DST_INC0)] <= acc_q;
        DST_POS0, DST_POS1, DST_POS2: pos_q[2'(uop.dst - DST_POS0)] <= acc_q;
        DST_ND0: nd0_q <= rsat;
        DST_ND1: nd1_q <= rsat;
        DST_ND2: begin
          dir_q[0] <= nd0_q;
          dir_q[1] <= nd1_q;
          dir_q[2] <= rsat;
        end
        default: ;
      endcase
    end
  end

  // The write count only grows while one draw is in progress.
  a_cnt_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC || state_q == S_PT) && ($past(state_q) == S_MAC
     || $past(state_q) == S_PT) |-> cnt_q >= $past(cnt_q))
    else $error("write count decreased during a draw");

  // A response only appears after the sequencer finished an item.
  a_rsp_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == S_DONE)
    else $error("response raised outside the finishing state");

  // Voxel writes only come from the index step of the micro-program.
  a_vox_uop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vox_we |-> uop_q == UOP_IDX_END && state_q != S_CLEAR)
    else $error("voxel write from an unexpected micro-operation");

  // The sequencer never leaves the micro-program.
  a_uop_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MAC |-> uop_q <= UOP_ROT_END)
    else $error("micro-program index out of range");

  // No request is taken during the clearing pass.
  a_clr_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |=> !($past(accept)))
    else $error("request taken while the volume is being cleared");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the voxel disc rasterizer
// Drives draw and read requests through the valid/ready request channel and
// checks every response against a bit-accurate model of the disc sweep and of
// the voxel volume, under random idling, long response stalls and several
// configuration settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vdr_pkg::*;

  localparam int unsigned DIM = 64;
  localparam longint VOL_CELLS = longint'(DIM) * DIM * DIM;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned IDLE_PCT = 31;

  typedef struct {
    logic req_type;
    logic signed [17:0] center_x, center_y, center_z;
    logic signed [15:0] axis_x, axis_y, axis_z;
    logic signed [15:0] start_x, start_y, start_z;
    logic [17:0] voxel_index;
  } disc_req_t;

  typedef struct {
    logic voxel_value;
    logic [23:0] voxels_written;
  } disc_rsp_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [15:0] cfg_data_i;

  vdr_req_if req ();
  vdr_rsp_if rsp ();

  voxel_disc_rasterizer_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .req_i(req),
    .rsp_o(rsp),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Shadow copy of the configuration and of the volume.
  logic [15:0] m_rot_cos, m_rot_sin, m_radius, m_step, m_scale_x, m_scale_y, m_scale_z;
  logic [10:0] m_angle_steps;
  bit volume_bits [0:262143];
  int unsigned recent_set [$];

  disc_rsp_t pending_rsp [$];
  int unsigned mismatches = 0;
  int unsigned n_draws = 0, n_reads = 0, n_checked = 0, n_settings = 0;
  bit quiet_req = 0, quiet_rsp = 0;
  int unsigned hold_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("tb NOT OK");
    $finish;
  end

  function automatic longint round_shift(longint v, int sh);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic logic [23:0] sweep_disc(disc_req_t it);
    longint a, s, steps, r, st, b, c, d, t, idx;
    longint sc[3], ctr[3], dir[3], nd[3], ds[3], p[3], mx[9];
    int unsigned cnt;
    cnt = 0;
    a = longint'($signed(m_rot_cos));
    s = longint'($signed(m_rot_sin));
    steps = (m_angle_steps == 0) ? 1 : m_angle_steps;
    r = m_radius;
    st = (m_step == 0) ? 1 : m_step;
    sc[0] = m_scale_x; sc[1] = m_scale_y; sc[2] = m_scale_z;
    ctr[0] = it.center_x; ctr[1] = it.center_y; ctr[2] = it.center_z;
    dir[0] = it.start_x; dir[1] = it.start_y; dir[2] = it.start_z;
    b = round_shift(longint'(it.axis_x) * s, 14);
    c = round_shift(longint'(it.axis_y) * s, 14);
    d = round_shift(longint'(it.axis_z) * s, 14);
    mx[0] = clamp16(round_shift(a * a + b * b - c * c - d * d, 14));
    mx[1] = clamp16(round_shift(b * c - d * a, 13));
    mx[2] = clamp16(round_shift(b * d + a * c, 13));
    mx[3] = clamp16(round_shift(b * c + a * d, 13));
    mx[4] = clamp16(round_shift(a * a + c * c - b * b - d * d, 14));
    mx[5] = clamp16(round_shift(c * d - a * b, 13));
    mx[6] = clamp16(round_shift(b * d - a * c, 13));
    mx[7] = clamp16(round_shift(c * d + a * b, 13));
    mx[8] = clamp16(round_shift(a * a + d * d - c * c - b * b, 14));
    for (longint k = 0; k < steps; k++) begin
      for (int i = 0; i < 3; i++) ds[i] = dir[i] * sc[i];
      t = -r;
      // At least one point is visited, even when the radius is zero.
      do begin
        for (int i = 0; i < 3; i++)
          p[i] = round_shift(ctr[i] * (longint'(1) << 26) + t * ds[i], 34);
        idx = p[2] + (p[1] + p[0] * DIM) * DIM;
        if (idx >= 0 && idx < VOL_CELLS) begin
          volume_bits[idx] = 1'b1;
          if (recent_set.size() < 64) recent_set.push_back(int'(idx));
          else recent_set[$urandom_range(63)] = int'(idx);
          if (cnt < 24'hFFFFFF) cnt++;
        end
        t += st;
      end while (t < r);
      for (int i = 0; i < 3; i++)
        nd[i] = clamp16(round_shift(mx[3*i] * dir[0] + mx[3*i+1] * dir[1]
                                    + mx[3*i+2] * dir[2], 14));
      for (int i = 0; i < 3; i++) dir[i] = nd[i];
    end
    return cnt[23:0];
  endfunction

  function automatic disc_rsp_t predict_rsp(disc_req_t it);
    disc_rsp_t o;
    if (it.req_type) begin
      o.voxel_value = (longint'(it.voxel_index) < VOL_CELLS) ? volume_bits[it.voxel_index] : 1'b0;
      o.voxels_written = '0;
    end else begin
      o.voxel_value = 1'b0;
      o.voxels_written = sweep_disc(it);
    end
    return o;
  endfunction

  // Response side: random stalls, an optional long hold-off, and the check.
  always @(posedge clk_i) begin
    disc_rsp_t e;
    if (rsp.valid && rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("response with no request outstanding");
        mismatches++;
      end else begin
        e = pending_rsp.pop_front();
        n_checked++;
        if (rsp.voxel_value !== e.voxel_value) begin
          $error("voxel_value expected %0d actual %0d", e.voxel_value, rsp.voxel_value);
          mismatches++;
        end
        if (rsp.voxels_written !== e.voxels_written) begin
          $error("voxels_written expected %0d actual %0d", e.voxels_written,
                 rsp.voxels_written);
          mismatches++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= quiet_rsp ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_req(disc_req_t it);
    if (!quiet_req && $urandom_range(99) < IDLE_PCT) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.req_type <= it.req_type;
    req.center_x <= it.center_x;
    req.center_y <= it.center_y;
    req.center_z <= it.center_z;
    req.axis_x <= it.axis_x;
    req.axis_y <= it.axis_y;
    req.axis_z <= it.axis_z;
    req.start_x <= it.start_x;
    req.start_y <= it.start_y;
    req.start_z <= it.start_z;
    req.voxel_index <= it.voxel_index;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    pending_rsp.push_back(predict_rsp(it));
    if (it.req_type) n_reads++;
    else n_draws++;
  endtask

  task automatic wait_idle();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_setup(logic [15:0] rc, logic [15:0] rs, logic [10:0] na,
                            logic [15:0] rad, logic [15:0] stp,
                            logic [15:0] sx, logic [15:0] sy, logic [15:0] sz);
    logic [15:0] vals [8];
    wait_idle();
    vals = '{rc, rs, {5'd0, na}, rad, stp, sx, sy, sz};
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= i[2:0];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    m_rot_cos = rc; m_rot_sin = rs; m_angle_steps = na;
    m_radius = rad; m_step = stp;
    m_scale_x = sx; m_scale_y = sy; m_scale_z = sz;
    n_settings++;
  endtask

  function automatic disc_req_t make_draw(int cx, int cy, int cz, int ax, int ay, int az,
                                          int sx, int sy, int sz);
    disc_req_t it;
    it.req_type = 1'b0;
    it.center_x = 18'(cx); it.center_y = 18'(cy); it.center_z = 18'(cz);
    it.axis_x = 16'(ax); it.axis_y = 16'(ay); it.axis_z = 16'(az);
    it.start_x = 16'(sx); it.start_y = 16'(sy); it.start_z = 16'(sz);
    it.voxel_index = 18'($urandom);
    return it;
  endfunction

  function automatic disc_req_t make_read(int unsigned idx);
    disc_req_t it;
    it = make_draw($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom);
    it.req_type = 1'b1;
    it.voxel_index = idx[17:0];
    return it;
  endfunction

  function automatic disc_req_t random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45)
      return make_draw($urandom_range(60 * 256, 4 * 256), $urandom_range(60 * 256, 4 * 256),
                       $urandom_range(60 * 256, 4 * 256),
                       int'($urandom_range(32767)) - 16384, int'($urandom_range(32767)) - 16384,
                       int'($urandom_range(32767)) - 16384,
                       int'($urandom_range(32767)) - 16384, int'($urandom_range(32767)) - 16384,
                       int'($urandom_range(32767)) - 16384);
    if (pick < 55)
      return make_draw($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom);
    if (pick < 85 && recent_set.size() != 0)
      return make_read(recent_set[$urandom_range(recent_set.size() - 1)]);
    return make_read($urandom);
  endfunction

  task automatic random_setup();
    logic [15:0] rad;
    rad = 16'($urandom_range(3072, 1));
    load_setup(16'($urandom), 16'($urandom), 11'($urandom_range(6, 1)), rad,
               16'($urandom_range(rad, rad / 24 + 1)),
               16'($urandom_range(6000, 2000)), 16'($urandom_range(6000, 2000)),
               16'($urandom));
  endtask

  task automatic test_reset_volume();
    send_req(make_read(0));
    send_req(make_read(262143));
    send_req(make_read($urandom));
    send_req(make_draw(32 * 256, 32 * 256, 32 * 256, 0, 0, 16384, 16384, 0, 0));
    send_req(make_read(recent_set[0]));
    send_req(make_read(recent_set[recent_set.size() - 1]));
    // Centre far outside the volume: nothing lands, nothing is counted.
    send_req(make_draw(-131072, 131071, -131072, 16384, 0, 0, 0, 16384, 0));
  endtask

  task automatic test_extremes();
    // Zero steps, zero step size and zero radius: a single point at the centre.
    load_setup(16'h8000, 16'h7FFF, 11'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd4096);
    send_req(make_draw(131071, -131072, 10 * 256 + 128, -32768, 32767, -32768,
                       32767, -32768, 32767));
    send_req(make_draw(5 * 256 + 128, 7 * 256 - 128, 9 * 256, 0, 0, 0, 0, 0, 0));
    send_req(make_read(recent_set[recent_set.size() - 1]));
    // Largest radius and step, largest scales, extreme rotation.
    load_setup(16'h7FFF, 16'h8000, 11'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_req(make_draw(32 * 256, 32 * 256, 32 * 256, 32767, -32768, 32767,
                       -32768, 32767, -32768));
    send_req(make_draw(0, 0, 0, 16384, 16384, 0, 1, -1, 1));
    // Many angle steps (1024) with a one-point line.
    load_setup(16'd16302, 16'd1636, 11'd1024, 16'd0, 16'd1, 16'd4096, 16'd4096, 16'd4096);
    send_req(make_draw(20 * 256, 40 * 256, 30 * 256, 0, 16384, 0, 16384, 0, 0));
    // Defaults again, with a disc whose points are rewritten many times.
    load_setup(16'd16302, 16'd1636, 11'd32, 16'd1280, 16'd128, 16'd4096, 16'd4096, 16'd4096);
    send_req(make_draw(33 * 256, 31 * 256, 30 * 256, 9459, 9459, 9459, 0, 16384, 0));
    send_req(make_read(recent_set[$urandom_range(recent_set.size() - 1)]));
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      random_setup();
      quiet_req = (phase == 2);
      quiet_rsp = (phase == 2);
      for (int n = 0; n < 24; n++) send_req(random_item());
    end
    quiet_req = 0;
    quiet_rsp = 0;
  endtask

  task automatic test_backpressure();
    random_setup();
    // Long enough for two of the longest draws, so the input stalls.
    hold_left = 20000;
    for (int n = 0; n < 12; n++) send_req(random_item());
    // Pause the request side until every response is back.
    wait_idle();
    for (int n = 0; n < 8; n++) send_req(random_item());
  endtask

  initial begin
    int unsigned guard;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    req.valid = 1'b0;
    req.req_type = 1'b0;
    req.center_x = '0; req.center_y = '0; req.center_z = '0;
    req.axis_x = '0; req.axis_y = '0; req.axis_z = '0;
    req.start_x = '0; req.start_y = '0; req.start_z = '0;
    req.voxel_index = '0;
    rsp.ready = 1'b0;
    m_rot_cos = 16'd16302; m_rot_sin = 16'd1636; m_angle_steps = 11'd32;
    m_radius = 16'd1280; m_step = 16'd128;
    m_scale_x = 16'd4096; m_scale_y = 16'd4096; m_scale_z = 16'd4096;
    for (int i = 0; i < 262144; i++) volume_bits[i] = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_volume();
    test_extremes();
    test_random_traffic();
    test_backpressure();

    req.valid <= 1'b0;
    guard = 0;
    while (pending_rsp.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_rsp.size() != 0) begin
      $error("%0d responses never arrived", pending_rsp.size());
      mismatches++;
    end
    $display("Covered %0d draws and %0d reads over %0d settings, %0d responses checked.",
             n_draws, n_reads, n_settings, n_checked);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ voxel_disc_rasterizer_top.f @@
hdl/vdr_pkg.sv
hdl/vdr_if.sv
hdl/voxel_disc_rasterizer_top.sv
tb/sv/tb.sv
